>>> hdl/sha1s_pkg.sv
// Package: SHA-1 constants, sequencer states and round helper functions.
`timescale 1ns / 1ps

package sha1s_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned FILL_W   = 6;
	localparam int unsigned ROUND_W  = 7;
	localparam int unsigned NUM_WORDS = 5;

	localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
	localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
	localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
	localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

	localparam logic [WORD_W-1:0] H0 = 32'h67452301;
	localparam logic [WORD_W-1:0] H1 = 32'hEFCDAB89;
	localparam logic [WORD_W-1:0] H2 = 32'h98BADCFE;
	localparam logic [WORD_W-1:0] H3 = 32'h10325476;
	localparam logic [WORD_W-1:0] H4 = 32'hC3D2E1F0;

	localparam logic [BYTE_W-1:0]  PAD_MARK   = 8'h80;
	localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
	localparam logic [IDX_W-1:0]   LAST_IDX   = 3'd4;
	localparam logic [FILL_W-1:0]  LAST_FILL  = 6'd63;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_FINAL = 5'b01000,
		ST_EMIT  = 5'b10000
	} sha1s_state_t;

	function automatic logic [WORD_W-1:0] sha1s_f(input logic [ROUND_W-1:0] rnd,
		input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] c,
		input logic [WORD_W-1:0] d);
		logic [WORD_W-1:0] r;
		if (rnd < 7'd20) begin
			r = (b & c) | (~b & d);
		end else if (rnd < 7'd40) begin
			r = b ^ c ^ d;
		end else if (rnd < 7'd60) begin
			r = (b & c) | (b & d) | (c & d);
		end else begin
			r = b ^ c ^ d;
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] sha1s_k(input logic [ROUND_W-1:0] rnd);
		logic [WORD_W-1:0] r;
		if (rnd < 7'd20) begin
			r = K0;
		end else if (rnd < 7'd40) begin
			r = K1;
		end else if (rnd < 7'd60) begin
			r = K2;
		end else begin
			r = K3;
		end
		return r;
	endfunction

endpackage

>>> hdl/sha1s_if.sv
// Interfaces: message byte channel and digest word channel.
`timescale 1ns / 1ps

interface sha1s_in_if import sha1s_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              has_byte;
	logic              last;

	modport source (output valid, data_byte, has_byte, last, input ready);
	modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

interface sha1s_out_if import sha1s_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  word_index;
	logic [WORD_W-1:0] digest_word;
	logic              last_word;

	modport source (output valid, word_index, digest_word, last_word, input ready);
	modport sink   (input valid, word_index, digest_word, last_word, output ready);
endinterface

>>> hdl/sha1_stream_hasher.sv
// Streaming SHA-1 hasher: byte intake, padding, iterative 80-round compression, digest out.
// A byte item that does not fill the block is taken in IDLE; one that fills it runs
// the 80 rounds on the single round adder, then a chaining update in FINAL.
// A last item shifts in padding bytes in PAD, plus a second padded block when the length
// needs one, runs the rounds and update for each block, then sends 5 digest words at one
// per cycle while the sink is ready. Bytes are accepted only in IDLE.
// Reset: arst_n clears the sequencer and restores the initial chaining words.
`timescale 1ns / 1ps

module sha1_stream_hasher import sha1s_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	sha1s_in_if.sink        msg,
	sha1s_out_if.source     digest
);

	sha1s_state_t state_q;

	logic [NUM_WORDS-1:0][WORD_W-1:0] h_q;
	logic [15:0][WORD_W-1:0]          win_q;
	logic [WORD_W-1:0]                a_q, b_q, c_q, d_q, e_q;
	logic [ROUND_W-1:0]               rnd_q;
	logic [FILL_W-1:0]                fill_q;
	logic [63:0]                      total_q;
	logic [63:0]                      len_q;
	logic [IDX_W-1:0]                 widx_q;
	logic                             last_q;
	logic                             mark_q;
	logic                             extra_q;

	logic              accept;
	logic              out_done;
	logic [63:0]       total_nx;
	logic [WORD_W-1:0] t_sum;
	logic [WORD_W-1:0] w_new;
	logic [BYTE_W-1:0] pad_byte;
	logic [WORD_W-1:0] out_word;

	assign msg.ready = (state_q == ST_IDLE);
	assign accept    = msg.valid && msg.ready;
	assign out_done  = digest.valid && digest.ready;
	assign total_nx  = total_q + {63'd0, msg.has_byte};

	assign t_sum = {a_q[26:0], a_q[31:27]} + sha1s_f(rnd_q, b_q, c_q, d_q) + e_q
		+ win_q[15] + sha1s_k(rnd_q);
	assign w_new = win_q[2] ^ win_q[7] ^ win_q[13] ^ win_q[15];

	always_comb begin
		if (!mark_q) begin
			pad_byte = PAD_MARK;
		end else if (fill_q[5:3] == 3'b111 && !extra_q) begin
			pad_byte = len_q[63:56];
		end else begin
			pad_byte = '0;
		end
	end

	always_comb begin
		case (widx_q)
			3'd0:    out_word = h_q[0];
			3'd1:    out_word = h_q[1];
			3'd2:    out_word = h_q[2];
			3'd3:    out_word = h_q[3];
			default: out_word = h_q[4];
		endcase
	end

	assign digest.valid       = (state_q == ST_EMIT);
	assign digest.word_index  = widx_q;
	assign digest.digest_word = out_word;
	assign digest.last_word   = (widx_q == LAST_IDX);

	// Block window: bytes shift in at the bottom; in rounds word 15 is W[t].
	always_ff @(posedge clk) begin
		if (accept && msg.has_byte) begin
			win_q <= {win_q[15][23:0], win_q[14:0], msg.data_byte};
		end else if (state_q == ST_PAD) begin
			win_q <= {win_q[15][23:0], win_q[14:0], pad_byte};
		end else if (state_q == ST_ROUND) begin
			win_q <= {win_q[14:0], w_new[30:0], w_new[31]};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ROUND) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t_sum;
		end else begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end
		if (accept && msg.last) begin
			len_q <= {total_nx[60:0], 3'b000};
		end else if (state_q == ST_PAD && mark_q && fill_q[5:3] == 3'b111 && !extra_q) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			h_q     <= {H4, H3, H2, H1, H0};
			rnd_q   <= '0;
			fill_q  <= '0;
			total_q <= '0;
			widx_q  <= '0;
			last_q  <= 1'b0;
			mark_q  <= 1'b0;
			extra_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						total_q <= total_nx;
						last_q  <= msg.last;
						if (msg.has_byte) begin
							fill_q <= fill_q + 6'd1;
						end
						rnd_q <= '0;
						if (msg.has_byte && fill_q == LAST_FILL) begin
							state_q <= ST_ROUND;
						end else if (msg.last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (!mark_q) begin
						mark_q  <= 1'b1;
						extra_q <= (fill_q[5:3] == 3'b111);
					end
					fill_q <= fill_q + 6'd1;
					rnd_q  <= '0;
					if (fill_q == LAST_FILL) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == LAST_ROUND) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					widx_q <= '0;
					if (mark_q && extra_q) begin
						extra_q <= 1'b0;
						state_q <= ST_PAD;
					end else if (mark_q) begin
						state_q <= ST_EMIT;
					end else if (last_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_done) begin
						widx_q <= widx_q + 3'd1;
						if (widx_q == LAST_IDX) begin
							// restart for the next message
							h_q     <= {H4, H3, H2, H1, H0};
							fill_q  <= '0;
							total_q <= '0;
							last_q  <= 1'b0;
							mark_q  <= 1'b0;
							extra_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_intake_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid |-> !msg.ready)
		else $error("message intake open while digest words pending");

	a_emit_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_EMIT) |-> $past(state_q == ST_FINAL))
		else $error("digest output started without a chaining update");

	a_restart_after_digest: assert property (@(posedge clk) disable iff (!arst_n)
		(out_done && digest.last_word) |=> (h_q[0] == H0 && fill_q == '0 && total_q == '0))
		else $error("hasher not restored after final digest word");

	a_round_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rnd_q <= LAST_ROUND))
		else $error("round counter out of range");

	a_word_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid |-> (widx_q <= LAST_IDX))
		else $error("digest word index out of range");
`endif

endmodule

>>> test/sha1_stream_hasher_test.sv
// Testbench for sha1_stream_hasher: directed and random message streams checked against a SHA-1 predictor.
`timescale 1ns / 1ps

module sha1_stream_hasher_test;

	typedef struct {
		logic [7:0] data;
		logic       has_byte;
		logic       last;
		bit         drain;
	} msg_item_t;

	typedef struct {
		logic [2:0]  index;
		logic [31:0] word;
		logic        last_word;
	} digest_word_t;

	logic clk;
	logic arst_n;

	sha1s_in_if  in_ch ();
	sha1s_out_if out_ch ();

	sha1_stream_hasher uut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (in_ch),
		.digest (out_ch)
	);

	// predictor state
	logic [31:0] chain [5];
	logic [7:0]  blk [64];
	int          fill;
	logic [63:0] total;

	msg_item_t    pending [$];
	digest_word_t digest_due [$];
	int           counted_items;
	int           words_expected;
	int           words_seen;
	int           errors;

	msg_item_t cur;
	bit        presenting;
	int        burst_left;
	int        gap_left;

	int        ready_mode;
	int        mode_left;
	int        stall_tick;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	task automatic restart_chain();
		chain[0] = 32'h67452301;
		chain[1] = 32'hEFCDAB89;
		chain[2] = 32'h98BADCFE;
		chain[3] = 32'h10325476;
		chain[4] = 32'hC3D2E1F0;
		fill = 0;
		total = '0;
	endtask

	task automatic compress_block();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++) begin
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		end
		for (int i = 16; i < 80; i++) begin
			w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		end
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = 32'h5A827999;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d;
				k = 32'hCA62C1D6;
			end
			t = rotl(a, 5) + f + e + w[i] + k;
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
		chain[4] += e;
		fill = 0;
	endtask

	// Take one accepted item into the predictor; a last item yields five digest words.
	task automatic absorb(input msg_item_t it);
		logic [63:0] bits;
		int p;
		digest_word_t dw;
		if (it.has_byte) begin
			blk[fill] = it.data;
			fill++;
			total++;
			if (fill == 64) begin
				compress_block();
			end
		end
		if (it.last) begin
			bits = total << 3;
			p = fill;
			blk[p] = 8'h80;
			p++;
			// length no longer fits: pad out and spend an extra block
			if (p > 56) begin
				while (p < 64) begin
					blk[p] = 8'h00;
					p++;
				end
				compress_block();
				p = 0;
			end
			while (p < 56) begin
				blk[p] = 8'h00;
				p++;
			end
			for (int i = 0; i < 8; i++) begin
				blk[56 + i] = bits[63 - 8*i -: 8];
			end
			compress_block();
			for (int j = 0; j < 5; j++) begin
				dw.index = 3'(j);
				dw.word = chain[j];
				dw.last_word = (j == 4);
				digest_due.push_back(dw);
				words_expected++;
			end
			restart_chain();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: %s: got %h, want %h", $time, what, got, want);
		errors++;
	endtask

	task automatic push_item(input logic [7:0] data, input logic has_byte,
		input logic last, input bit drain);
		msg_item_t it;
		it.data = data;
		it.has_byte = has_byte;
		it.last = last;
		it.drain = drain;
		pending.push_back(it);
		if (has_byte || last) begin
			counted_items++;
		end
	endtask

	// Queue one message; noops land between bytes now and then.
	task automatic push_message(input int len, input bit last_on_byte, input bit drain);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				push_item(8'($urandom), 1'b0, 1'b0, drain && i == 0);
			end
			push_item(8'($urandom), 1'b1, last_on_byte && i == len - 1, drain && i == 0);
		end
		if (!(last_on_byte && len > 0)) begin
			push_item(8'($urandom), 1'b0, 1'b1, drain && len == 0);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver: present pending items in bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data_byte <= '0;
			in_ch.has_byte <= 1'b0;
			in_ch.last <= 1'b0;
			presenting = 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				absorb(cur);
				presenting = 1'b0;
				if (burst_left > 0) begin
					burst_left--;
				end
			end
			if (!presenting) begin
				if (burst_left == 0 && gap_left == 0) begin
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
						: $urandom_range(1, 8);
				end
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending.size() > 0
					&& !(pending[0].drain && words_expected != words_seen)) begin
					cur = pending.pop_front();
					presenting = 1'b1;
				end
			end
			in_ch.valid <= presenting;
			in_ch.data_byte <= cur.data;
			in_ch.has_byte <= cur.has_byte;
			in_ch.last <= cur.last;
		end
	end

	// monitor: stall on a changing pattern and check every accepted digest word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			ready_mode = 0;
			mode_left = 0;
			stall_tick = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				words_seen <= words_seen + 1;
				if (digest_due.size() == 0) begin
					report_mismatch("digest word with nothing pending", out_ch.digest_word, '0);
				end else begin
					if (out_ch.word_index !== digest_due[0].index) begin
						report_mismatch("word_index", 32'(out_ch.word_index),
							32'(digest_due[0].index));
					end
					if (out_ch.digest_word !== digest_due[0].word) begin
						report_mismatch("digest_word", out_ch.digest_word, digest_due[0].word);
					end
					if (out_ch.last_word !== digest_due[0].last_word) begin
						report_mismatch("last_word", 32'(out_ch.last_word),
							32'(digest_due[0].last_word));
					end
					void'(digest_due.pop_front());
				end
			end
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			stall_tick++;
			case (ready_mode)
				0: begin
					out_ch.ready <= 1'b1;
				end
				1: begin
					out_ch.ready <= 1'($urandom_range(0, 1));
				end
				2: begin
					out_ch.ready <= ($urandom_range(0, 3) == 0);
				end
				default: begin
					out_ch.ready <= (stall_tick % 4 != 0);
				end
			endcase
		end
	end

	initial begin
		int len;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.has_byte = 1'b0;
		in_ch.last = 1'b0;
		out_ch.ready = 1'b0;
		counted_items = 0;
		words_expected = 0;
		words_seen = 0;
		errors = 0;
		cur = '{data: '0, has_byte: 1'b0, last: 1'b0, drain: 1'b0};
		for (int i = 0; i < 64; i++) begin
			blk[i] = 8'h00;
		end
		restart_chain();

		// directed: noops, empty messages back to back, extreme bytes, a short message
		push_item(8'h00, 1'b0, 1'b0, 1'b0);
		push_item(8'hFF, 1'b0, 1'b0, 1'b0);
		push_item(8'h00, 1'b0, 1'b1, 1'b0);
		push_item(8'hFF, 1'b0, 1'b1, 1'b0);
		push_item(8'h00, 1'b1, 1'b1, 1'b0);
		push_item(8'hFF, 1'b1, 1'b0, 1'b1);
		push_item(8'h5A, 1'b0, 1'b1, 1'b0);
		push_item(8'h61, 1'b1, 1'b0, 1'b0);
		push_item(8'hA5, 1'b0, 1'b0, 1'b0);
		push_item(8'h62, 1'b1, 1'b0, 1'b0);
		push_item(8'h63, 1'b1, 1'b1, 1'b0);
		push_item(8'h80, 1'b1, 1'b0, 1'b1);
		push_item(8'h7F, 1'b1, 1'b1, 1'b0);

		// padding boundaries: extra block needed, then last on the byte that fills a block
		push_message(56, 1'b1, 1'b1);
		push_message(64, 1'b1, 1'b0);
		while (counted_items < 160) begin
			len = ($urandom_range(0, 11) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
			push_message(len, 1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || presenting) begin
			@(posedge clk);
		end
		while (digest_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (300) @(posedge clk);
		if (digest_due.size() != 0) begin
			report_mismatch("digest words never received", 32'(digest_due.size()), '0);
		end
		if (errors == 0) begin
			$display("sha1_stream_hasher_test OK");
		end else begin
			$display("sha1_stream_hasher_test NOT OK");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("sha1_stream_hasher_test NOT OK");
		$finish;
	end

endmodule
